// ----- sv/acm_pkg.sv -----
package acm_pkg;

  localparam int AXES_DEF        = 16;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int CODE_W          = 32;
  localparam int PAYLOAD_W       = 64;
  localparam int CFG_INDEX_W     = 2;

  typedef enum logic [2:0] {
    OP_PUBLISH   = 3'd0,
    OP_POP       = 3'd1,
    OP_TAKE      = 3'd2,
    OP_FLUSH     = 3'd3,
    OP_FLUSH_ALL = 3'd4,
    OP_HAS_SPACE = 3'd5
  } op_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CODE_NOP        = 2'd0,
    REG_CODE_STOP       = 2'd1,
    REG_CODE_QUICK_STOP = 2'd2,
    REG_CODE_SERVO_OFF  = 2'd3
  } cfg_reg_e;

  // Safety latch ranks, ordered so that a larger rank wins.
  localparam logic [1:0] RANK_NONE       = 2'd0;
  localparam logic [1:0] RANK_STOP       = 2'd1;
  localparam logic [1:0] RANK_QUICK_STOP = 2'd2;
  localparam logic [1:0] RANK_SERVO_OFF  = 2'd3;

  typedef struct packed {
    logic [2:0]                operation;
    logic [3:0]                axis;
    logic signed [CODE_W-1:0]  command;
    logic [PAYLOAD_W-1:0]      payload;
  } req_t;

  typedef struct packed {
    logic                      ok;
    logic signed [CODE_W-1:0]  out_command;
    logic [PAYLOAD_W-1:0]      out_payload;
    logic                      ring_full_fault;
  } rsp_t;

  typedef struct packed {
    logic signed [CODE_W-1:0]  command;
    logic [PAYLOAD_W-1:0]      payload;
  } slot_t;

endpackage

// ----- sv/axis_command_mailbox_core.sv -----
// Per-axis command mailbox with a safety latch.
// Command channel: a request is transferred at a rising edge with start high and
// busy low. The block then raises busy for one cycle while it works on the request,
// and the response appears on result with done high for exactly one cycle after
// that. A new request cannot be transferred while busy; it can be transferred
// in the cycle in which the previous response is shown. The block works on one
// request at a time because of the slot memory: its read takes the transfer
// cycle, and the read-modify-write of pointers, latch and memory takes the
// busy cycle, which keeps accesses to one slot from overlapping.
// Configuration: a write of cfg_data to the code register cfg_index is
// transferred when cfg_valid and cfg_ready are high; cfg_ready is always high.
// Write codes only while no request is in progress.
// Reset clears all ring pointers, latches, the fault flag and the codes to their
// defaults; slot contents are not cleared and need no clearing pass. The
// receiver of results cannot stall: each response is shown for one cycle only.
module axis_command_mailbox_core #(
  parameter int AXES        = acm_pkg::AXES_DEF,
  parameter int QUEUE_DEPTH = acm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  acm_pkg::req_t                        request,
  output logic                                 done,
  output acm_pkg::rsp_t                        result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [acm_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [acm_pkg::CODE_W-1:0]           cfg_data
);
  import acm_pkg::*;

  localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int PW  = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t                   state;
  state_t                   state_next;

  logic signed [CODE_W-1:0] code_nop;
  logic signed [CODE_W-1:0] code_stop;
  logic signed [CODE_W-1:0] code_quick_stop;
  logic signed [CODE_W-1:0] code_servo_off;

  logic [PW-1:0]            heads [AXES];
  logic [PW-1:0]            tails [AXES];
  logic [1:0]               ranks [AXES];
  logic                     fault_flag;
  logic                     fault_flag_next;

  req_t                     req;
  logic [AXW-1:0]           req_axis;
  logic                     req_axis_ok;

  logic                     accept;
  logic [AXW+3:0]           in_axis_ext;
  logic [AXW-1:0]           in_axis;
  logic                     in_axis_ok;

  logic [PW-1:0]            head_cur;
  logic [PW-1:0]            tail_cur;
  logic [1:0]               rank_cur;
  logic [PW-1:0]            head_adv;
  logic [PW-1:0]            tail_adv;
  logic [1:0]               cmd_rank;

  logic                     head_we;
  logic                     tail_we;
  logic [PW-1:0]            tail_next;
  logic                     rank_we;
  logic [1:0]               rank_next;
  logic                     flush_all;
  logic                     mem_we;
  slot_t                    mem_rd;
  slot_t                    mem_wr;
  rsp_t                     rsp_next;

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
    logic [PW:0] inc;
    begin
      inc = {1'b0, p} + (PW+1)'(1);
      advance = (inc == (PW+1)'(QUEUE_DEPTH)) ? '0 : inc[PW-1:0];
    end
  endfunction

  assign accept      = start && !busy;
  assign busy        = (state == ST_EXEC);
  assign cfg_ready   = 1'b1;
  assign in_axis_ext = (AXW+4)'(request.axis);
  assign in_axis     = in_axis_ext[AXW-1:0];
  assign in_axis_ok  = 32'(request.axis) < 32'(AXES);

  always_ff @(posedge clk) begin
    if (rst) begin
      code_nop        <= 32'sd0;
      code_stop       <= 32'sd1;
      code_quick_stop <= 32'sd2;
      code_servo_off  <= 32'sd3;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_CODE_NOP:        code_nop        <= cfg_data;
        REG_CODE_STOP:       code_stop       <= cfg_data;
        REG_CODE_QUICK_STOP: code_quick_stop <= cfg_data;
        REG_CODE_SERVO_OFF:  code_servo_off  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req         <= request;
      req_axis    <= in_axis;
      req_axis_ok <= in_axis_ok;
    end
  end

  // The slot at the tail is read during the transfer cycle so that a pop has
  // its entry ready in the busy cycle.
  acm_slot_mem #(
    .AXES        (AXES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_slot_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_axis (req_axis),
    .wr_ptr  (head_cur),
    .wr_data (mem_wr),
    .rd_en   (accept),
    .rd_axis (in_axis),
    .rd_ptr  (tails[in_axis]),
    .rd_data (mem_rd)
  );

  assign head_cur = heads[req_axis];
  assign tail_cur = tails[req_axis];
  assign rank_cur = ranks[req_axis];
  assign head_adv = advance(head_cur);
  assign tail_adv = advance(tail_cur);
  assign mem_wr   = '{command: req.command, payload: req.payload};

  // Servo off is checked first so that it wins when codes coincide.
  always_comb begin
    if (req.command == code_servo_off) begin
      cmd_rank = RANK_SERVO_OFF;
    end else if (req.command == code_quick_stop) begin
      cmd_rank = RANK_QUICK_STOP;
    end else if (req.command == code_stop) begin
      cmd_rank = RANK_STOP;
    end else begin
      cmd_rank = RANK_NONE;
    end
  end

  always_comb begin
    state_next      = state;
    head_we         = 1'b0;
    tail_we         = 1'b0;
    tail_next       = head_cur;
    rank_we         = 1'b0;
    rank_next       = RANK_NONE;
    flush_all       = 1'b0;
    mem_we          = 1'b0;
    fault_flag_next = fault_flag;
    rsp_next        = '0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
        if (req.operation == OP_FLUSH_ALL) begin
          flush_all = 1'b1;
        end else if (!req_axis_ok) begin
          if (req.operation == OP_TAKE) begin
            rsp_next.out_command = code_nop;
          end
        end else begin
          case (req.operation)
            OP_PUBLISH: begin
              if (cmd_rank != RANK_NONE) begin
                rsp_next.ok = 1'b1;
                if (cmd_rank > rank_cur) begin
                  rank_we   = 1'b1;
                  rank_next = cmd_rank;
                end
              end else if (head_adv == tail_cur) begin
                fault_flag_next = 1'b1;
              end else begin
                mem_we      = 1'b1;
                head_we     = 1'b1;
                rsp_next.ok = 1'b1;
              end
            end
            OP_POP: begin
              if (tail_cur != head_cur) begin
                rsp_next.ok          = 1'b1;
                rsp_next.out_command = mem_rd.command;
                rsp_next.out_payload = mem_rd.payload;
                tail_we              = 1'b1;
                tail_next            = tail_adv;
              end
            end
            OP_TAKE: begin
              rank_we = 1'b1;
              case (rank_cur)
                RANK_SERVO_OFF:  rsp_next.out_command = code_servo_off;
                RANK_QUICK_STOP: rsp_next.out_command = code_quick_stop;
                RANK_STOP:       rsp_next.out_command = code_stop;
                default:         rsp_next.out_command = code_nop;
              endcase
              rsp_next.ok = (rank_cur != RANK_NONE);
              tail_we     = (rsp_next.out_command != code_nop);
            end
            OP_FLUSH: begin
              tail_we = 1'b1;
            end
            OP_HAS_SPACE: begin
              rsp_next.ok = (head_adv != tail_cur);
            end
            default: ;
          endcase
        end
        rsp_next.ring_full_fault = fault_flag_next;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fault_flag <= 1'b0;
      done       <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        heads[a] <= '0;
        tails[a] <= '0;
        ranks[a] <= RANK_NONE;
      end
    end else begin
      state      <= state_next;
      fault_flag <= fault_flag_next;
      done       <= (state == ST_EXEC);
      if (flush_all) begin
        for (int a = 0; a < AXES; a++) begin
          tails[a] <= heads[a];
          ranks[a] <= RANK_NONE;
        end
      end else begin
        if (head_we) begin
          heads[req_axis] <= head_adv;
        end
        if (tail_we) begin
          tails[req_axis] <= tail_next;
        end
        if (rank_we) begin
          ranks[req_axis] <= rank_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      result <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_EXEC))
    else $error("response strobe without a preceding busy cycle");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("request transfer not followed by a busy cycle");

  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    fault_flag |=> fault_flag)
    else $error("ring full fault cleared without reset");

  a_fault_reported: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.ring_full_fault == fault_flag))
    else $error("reported fault differs from the fault flag");
`endif

endmodule

// ----- sv/acm_slot_mem.sv -----
module acm_slot_mem #(
  parameter int AXES        = acm_pkg::AXES_DEF,
  parameter int QUEUE_DEPTH = acm_pkg::QUEUE_DEPTH_DEF,
  localparam int AXW        = (AXES > 1) ? $clog2(AXES) : 1,
  localparam int PW         = $clog2(QUEUE_DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AXW-1:0]       wr_axis,
  input  logic [PW-1:0]        wr_ptr,
  input  acm_pkg::slot_t       wr_data,
  input  logic                 rd_en,
  input  logic [AXW-1:0]       rd_axis,
  input  logic [PW-1:0]        rd_ptr,
  output acm_pkg::slot_t       rd_data
);
  import acm_pkg::*;

  localparam int SLOTS  = AXES * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(SLOTS);

  slot_t             slots [SLOTS];
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  // Each axis owns a contiguous block of QUEUE_DEPTH slots.
  assign wr_addr = ADDR_W'(wr_axis) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(wr_ptr);
  assign rd_addr = ADDR_W'(rd_axis) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(rd_ptr);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= slots[rd_addr];
    end
  end

endmodule
